// ===== rtl/anrp_pkg.sv =====
// Shared constants and types for the aligned nonzero row partitioner.
package anrp_pkg;

  localparam int MAX_PARTS   = 64;
  localparam int IDX_W       = 7;
  localparam int NNZ_W       = 32;
  localparam int RUN_W       = 33;
  localparam int OUT_ROW_W   = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int ALIGN_W     = 4;
  localparam int ALIGN_MAX   = (1 << ALIGN_W) - 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_ROWS      = 2'd2;

  // One queued run of boundaries: indexes lo to hi, all ending at the same row.
  typedef struct packed {
    logic [IDX_W-1:0]     lo;
    logic [IDX_W-1:0]     hi;
    logic                 last;
    logic [OUT_ROW_W-1:0] row;
  } anrp_task_t;

endpackage

// ===== rtl/anrp_in_if.sv =====
// Input channel carrying one row nonzero count per transaction.
interface anrp_in_if;
  logic                       valid;
  logic                       ready;
  logic [anrp_pkg::NNZ_W-1:0] row_nnz;
  logic                       is_last_row;

  modport source (output valid, output row_nnz, output is_last_row, input ready);
  modport sink (input valid, input row_nnz, input is_last_row, output ready);
endinterface

// ===== rtl/anrp_out_if.sv =====
// Result channel carrying one partition boundary per transaction.
interface anrp_out_if;
  logic                           valid;
  logic                           ready;
  logic [anrp_pkg::IDX_W-1:0]     boundary_index;
  logic [anrp_pkg::OUT_ROW_W-1:0] boundary_row;
  logic                           last_boundary;

  modport source (output valid, output boundary_index, output boundary_row,
                  output last_boundary, input ready);
  modport sink (input valid, input boundary_index, input boundary_row,
                input last_boundary, output ready);
endinterface

// ===== rtl/aligned_nnz_row_partition.sv =====
// Top level of the aligned nonzero-balanced row partitioner.
// Usage: the input channel takes one transaction per sparse-matrix row, in
// order, carrying the row's nonzero count and a flag on the final row of the
// range. The result channel gives partition boundaries (index, exclusive end
// row, final flag); boundary 0 is always row 0 and is never sent.
// Configuration is written through the cfg_ port while no transaction is in
// flight; part_count, split_threshold and align_rows take effect at once.
// Throughput: one row per cycle while the queue is not full. A row that
// closes a partition gives one result; the final row gives a run of results
// up to part_count, all ending at the total row count. The back end's output
// register sets the rate of results: one per cycle while out_ch.ready holds.
// A result passes through the queue and then the output register after its
// row is accepted. A four-entry queue between classification and output lets
// rows keep flowing while the receiver stalls; once it fills, in_ch.ready drops.
// Reset returns the counts to zero, part_count and align_rows to 1 and
// split_threshold to 0; no clearing pass is needed.
module aligned_nnz_row_partition #(
  parameter int ROW_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  anrp_in_if.sink                         in_ch,
  anrp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [anrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [anrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import anrp_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  anrp_task_t q_data;
  anrp_task_t q_head;

  anrp_front #(
    .ROW_BITS (ROW_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  anrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  anrp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // The front end must never write into a full queue.
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  // The back end takes a run only when one is waiting.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // Every boundary sent lies between 1 and the largest part count.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.boundary_index != '0) &&
                     (out_ch.boundary_index <= IDX_W'(MAX_PARTS)))
    else $error("boundary index out of range");

endmodule

// ===== rtl/anrp_front.sv =====
// Front end: configuration registers, running counts and boundary classification.
module anrp_front #(
  parameter int ROW_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  anrp_in_if.sink                          in_ch,
  input  logic                             cfg_we,
  input  logic [anrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [anrp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             q_full,
  output logic                             q_push,
  output anrp_pkg::anrp_task_t             q_data
);
  import anrp_pkg::*;

  logic [IDX_W-1:0]     part_count_r;
  logic [NNZ_W-1:0]     thr_r;
  logic [ALIGN_W-1:0]   align_r;

  logic [RUN_W-1:0]     run_r, run_nxt;
  logic [ROW_BITS-1:0]  rows_r, rows_nxt;
  logic [IDX_W-1:0]     splits_r, splits_nxt;
  logic [ALIGN_W-1:0]   res_r   [2:ALIGN_MAX];
  logic [ALIGN_W-1:0]   res_nxt [2:ALIGN_MAX];

  logic                 accept;
  logic [RUN_W:0]       run_sum;
  logic [RUN_W-1:0]     run_sat;
  logic                 wrap;
  logic [ALIGN_MAX:0]   zero_vec;
  logic [IDX_W-1:0]     parts_eff;
  logic                 split_fire;
  logic                 emit_split;
  logic [IDX_W-1:0]     splits_after;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    if (part_count_r == '0) begin
      parts_eff = IDX_W'(1);
    end else if (part_count_r > IDX_W'(MAX_PARTS)) begin
      parts_eff = IDX_W'(MAX_PARTS);
    end else begin
      parts_eff = part_count_r;
    end
  end

  // The residue of the row count is kept for every possible alignment, so a
  // change of alignment between ranges or mid-range needs no divider.
  assign wrap = &rows_r;

  always_comb begin
    zero_vec    = '0;
    zero_vec[0] = 1'b1;
    zero_vec[1] = 1'b1;
    for (int d = 2; d <= ALIGN_MAX; d++) begin
      if (wrap || res_r[d] == ALIGN_W'(d - 1)) begin
        res_nxt[d] = '0;
      end else begin
        res_nxt[d] = res_r[d] + 1'b1;
      end
      zero_vec[d] = (res_nxt[d] == '0);
    end
  end

  always_comb begin
    run_sum      = {1'b0, run_r} + (RUN_W + 1)'(in_ch.row_nnz);
    run_sat      = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];
    rows_nxt     = rows_r + 1'b1;
    split_fire   = (run_sat >= RUN_W'(thr_r)) && zero_vec[align_r];
    emit_split   = split_fire && ((splits_r + 1'b1) < parts_eff);
    splits_after = splits_r + IDX_W'(emit_split);
    run_nxt      = split_fire ? '0 : run_sat;
    splits_nxt   = splits_after;

    q_data.row  = OUT_ROW_W'(rows_nxt);
    q_data.last = in_ch.is_last_row;
    if (in_ch.is_last_row) begin
      q_data.hi = parts_eff;
      if (emit_split) begin
        q_data.lo = splits_after;
      end else if (splits_after >= parts_eff) begin
        q_data.lo = parts_eff;
      end else begin
        q_data.lo = splits_after + 1'b1;
      end
    end else begin
      q_data.lo = splits_after;
      q_data.hi = splits_after;
    end
    q_push = accept && (emit_split || in_ch.is_last_row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= IDX_W'(1);
      thr_r        <= '0;
      align_r      <= ALIGN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PART_COUNT:      part_count_r <= cfg_data[IDX_W-1:0];
        REG_SPLIT_THRESHOLD: thr_r        <= cfg_data[NNZ_W-1:0];
        REG_ALIGN_ROWS:      align_r      <= cfg_data[ALIGN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= '0;
      rows_r   <= '0;
      splits_r <= '0;
      for (int d = 2; d <= ALIGN_MAX; d++) begin
        res_r[d] <= '0;
      end
    end else if (accept) begin
      if (in_ch.is_last_row) begin
        run_r    <= '0;
        rows_r   <= '0;
        splits_r <= '0;
        for (int d = 2; d <= ALIGN_MAX; d++) begin
          res_r[d] <= '0;
        end
      end else begin
        run_r    <= run_nxt;
        rows_r   <= rows_nxt;
        splits_r <= splits_nxt;
        for (int d = 2; d <= ALIGN_MAX; d++) begin
          res_r[d] <= res_nxt[d];
        end
      end
    end
  end

endmodule

// ===== rtl/anrp_queue.sv =====
// Short first-in first-out queue of boundary runs between front and back end.
module anrp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  anrp_pkg::anrp_task_t push_data,
  output logic                 full,
  input  logic                 pop,
  output anrp_pkg::anrp_task_t head,
  output logic                 empty
);
  import anrp_pkg::*;

  anrp_task_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/anrp_back.sv =====
// Back end: walks each queued run of boundaries into the output register.
module anrp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  anrp_pkg::anrp_task_t head,
  input  logic                 q_empty,
  output logic                 q_pop,
  anrp_out_if.source           out_ch
);
  import anrp_pkg::*;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic                 out_last_r;
  logic                 busy_r;
  logic [IDX_W-1:0]     cur_r;

  logic                 load;
  logic                 issue;
  logic [IDX_W-1:0]     idx;
  logic                 at_end;

  assign load   = !out_valid_r || out_ch.ready;
  assign issue  = !q_empty && load;
  assign idx    = busy_r ? cur_r : head.lo;
  assign at_end = (idx == head.hi);
  assign q_pop  = issue && at_end;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.boundary_index = out_idx_r;
  assign out_ch.boundary_row   = out_row_r;
  assign out_ch.last_boundary  = out_last_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      out_idx_r  <= idx;
      out_row_r  <= head.row;
      out_last_r <= head.last && at_end;
      cur_r      <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= issue;
      end
      if (issue) begin
        busy_r <= !at_end;
      end
    end
  end

endmodule
